// ===== sv/record_ring_offset_lookup_macros.svh =====
// ----------------------------------------------------------------------------
// record ring offset lookup - assertion macros
// ----------------------------------------------------------------------------
`ifndef RECORD_RING_OFFSET_LOOKUP_MACROS_SVH
`define RECORD_RING_OFFSET_LOOKUP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RROL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rrol assertion failed");

// next-cycle implication, disabled while in reset
`define RROL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rrol assertion failed");

`endif

// ===== sv/rrol_pkg.sv =====
// ----------------------------------------------------------------------------
// rrol_pkg
// shared types and constants of the record ring offset lookup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrol_pkg;

  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int LEN_W      = 16;
  localparam int HDL_W      = 32;
  localparam int POS_W      = 20;
  localparam int SUM_W      = LEN_W + IDX_W + 1;
  localparam int CMP_W      = (SUM_W > POS_W) ? SUM_W : POS_W;
  localparam int ENT_W      = LEN_W + HDL_W;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } rrol_state_e;

  typedef struct packed {
    logic start;
    logic add_wr;
    logic issue;
    logic issue_last;
    logic check_en;
    logic load_out;
    logic out_sel_res;
  } rrol_cmd_t;

  typedef struct packed {
    logic hit;
    logic last_chk;
  } rrol_sts_t;

endpackage

`default_nettype wire

// ===== sv/rrol_in_if.sv =====
// ----------------------------------------------------------------------------
// rrol_in_if
// request channel: add or find word with valid / ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rrol_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [rrol_pkg::LEN_W-1:0] record_length;
  logic [rrol_pkg::HDL_W-1:0] record_handle;
  logic [rrol_pkg::POS_W-1:0] byte_position;

  modport source (
    output valid, operation, record_length, record_handle, byte_position,
    input  ready
  );

  modport sink (
    input  valid, operation, record_length, record_handle, byte_position,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/rrol_out_if.sv =====
// ----------------------------------------------------------------------------
// rrol_out_if
// result channel: lookup word with valid / ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rrol_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [rrol_pkg::HDL_W-1:0] found_handle;
  logic [rrol_pkg::LEN_W-1:0] found_length;
  logic [rrol_pkg::LEN_W-1:0] offset_in_record;

  modport source (
    output valid, found, found_handle, found_length, offset_in_record,
    input  ready
  );

  modport sink (
    input  valid, found, found_handle, found_length, offset_in_record,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/rrol_ram.sv =====
// ----------------------------------------------------------------------------
// rrol_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/rrol_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrol_ctrl
// controller: sequences adds, the find walk and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrol_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_operation_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire rrol_pkg::rrol_sts_t sts_i,
  output rrol_pkg::rrol_cmd_t      cmd_o
);
  import rrol_pkg::*;

  rrol_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_operation_i == OP_FIND)) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts_i.hit || sts_i.last_chk) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation_i == OP_ADD) begin
            cmd_o.add_wr   = 1'b1;
            cmd_o.load_out = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd_o.check_en   = 1'b1;
        cmd_o.issue      = (cnt_q != CNT_W'(RING_DEPTH));
        cmd_o.issue_last = (cnt_q == CNT_W'(RING_DEPTH - 1));
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out    = 1'b1;
          cmd_o.out_sel_res = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_o.start) begin
      cnt_d = '0;
    end else if (cmd_o.issue) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/rrol_dp.sv =====
// ----------------------------------------------------------------------------
// rrol_dp
// datapath: ring pointers, descriptor store, length accumulator, result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrol_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rrol_pkg::rrol_cmd_t        cmd_i,
  output rrol_pkg::rrol_sts_t             sts_o,
  input  wire logic [rrol_pkg::LEN_W-1:0] record_length_i,
  input  wire logic [rrol_pkg::HDL_W-1:0] record_handle_i,
  input  wire logic [rrol_pkg::POS_W-1:0] byte_position_i,
  output logic                            found_o,
  output logic      [rrol_pkg::HDL_W-1:0] found_handle_o,
  output logic      [rrol_pkg::LEN_W-1:0] found_length_o,
  output logic      [rrol_pkg::LEN_W-1:0] offset_in_record_o
);
  import rrol_pkg::*;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
    return (s == IDX_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  logic [IDX_W-1:0]      wr_slot_q, wr_slot_d;
  logic [IDX_W-1:0]      old_slot_q, old_slot_d;
  logic [IDX_W-1:0]      walk_slot_q, walk_slot_d;
  logic                  full_q, full_d;
  logic [RING_DEPTH-1:0] vld_q, vld_d;
  logic                  vld_rd_q;
  logic                  chk_q, chk_last_q;
  logic [POS_W-1:0]      pos_q;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [ENT_W-1:0]      rd_data;
  logic [LEN_W-1:0]      cur_len;
  logic [CMP_W-1:0]      span;
  logic [CMP_W-1:0]      diff;
  logic                  hit;

  logic                  res_found_q;
  logic [HDL_W-1:0]      res_handle_q;
  logic [LEN_W-1:0]      res_len_q;
  logic [LEN_W-1:0]      res_off_q;

  logic                  out_found_q;
  logic [HDL_W-1:0]      out_handle_q;
  logic [LEN_W-1:0]      out_len_q;
  logic [LEN_W-1:0]      out_off_q;

  rrol_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RING_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add_wr),
    .waddr_i (wr_slot_q),
    .wdata_i ({record_handle_i, record_length_i}),
    .re_i    (cmd_i.issue),
    .raddr_i (walk_slot_q),
    .rdata_o (rd_data)
  );

  // a slot never written reads as length zero
  assign cur_len = vld_rd_q ? rd_data[LEN_W-1:0] : '0;
  assign span    = CMP_W'(sum_q) + CMP_W'(cur_len);
  assign diff    = CMP_W'(pos_q) - CMP_W'(sum_q);
  assign hit     = chk_q && (span > CMP_W'(pos_q));

  assign sts_o.hit      = hit;
  assign sts_o.last_chk = chk_q && chk_last_q;

  // ring pointers
  always_comb begin
    wr_slot_d  = wr_slot_q;
    old_slot_d = old_slot_q;
    full_d     = full_q;
    vld_d      = vld_q;
    if (cmd_i.add_wr) begin
      vld_d[wr_slot_q] = 1'b1;
      wr_slot_d        = next_slot(wr_slot_q);
      if (full_q) begin
        old_slot_d = next_slot(old_slot_q);
      end else if (next_slot(wr_slot_q) == old_slot_q) begin
        full_d = 1'b1;
      end
    end
  end

  always_comb begin
    walk_slot_d = walk_slot_q;
    if (cmd_i.start) begin
      walk_slot_d = old_slot_q;
    end else if (cmd_i.issue) begin
      walk_slot_d = next_slot(walk_slot_q);
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.start) begin
      sum_d = '0;
    end else if (cmd_i.check_en && chk_q) begin
      sum_d = sum_q + SUM_W'(cur_len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q  <= '0;
      old_slot_q <= '0;
      full_q     <= 1'b0;
      vld_q      <= '0;
      chk_q      <= 1'b0;
      chk_last_q <= 1'b0;
    end else begin
      wr_slot_q  <= wr_slot_d;
      old_slot_q <= old_slot_d;
      full_q     <= full_d;
      vld_q      <= vld_d;
      chk_q      <= cmd_i.issue;
      chk_last_q <= cmd_i.issue_last;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_slot_q <= walk_slot_d;
    sum_q       <= sum_d;
    if (cmd_i.issue) begin
      vld_rd_q <= vld_q[walk_slot_q];
    end
    if (cmd_i.start) begin
      pos_q        <= byte_position_i;
      res_found_q  <= 1'b0;
      res_handle_q <= '0;
      res_len_q    <= '0;
      res_off_q    <= '0;
    end else if (cmd_i.check_en && hit) begin
      res_found_q  <= 1'b1;
      res_handle_q <= rd_data[ENT_W-1:LEN_W];
      res_len_q    <= cur_len;
      res_off_q    <= diff[LEN_W-1:0];
    end
    if (cmd_i.load_out) begin
      if (cmd_i.out_sel_res) begin
        out_found_q  <= res_found_q;
        out_handle_q <= res_handle_q;
        out_len_q    <= res_len_q;
        out_off_q    <= res_off_q;
      end else begin
        out_found_q  <= 1'b0;
        out_handle_q <= '0;
        out_len_q    <= '0;
        out_off_q    <= '0;
      end
    end
  end

  assign found_o            = out_found_q;
  assign found_handle_o     = out_handle_q;
  assign found_length_o     = out_len_q;
  assign offset_in_record_o = out_off_q;

endmodule

`default_nettype wire

// ===== sv/record_ring_offset_lookup.sv =====
// ----------------------------------------------------------------------------
// record_ring_offset_lookup
// ring of record descriptors that overwrites the oldest; finds the record
// holding a byte position of all records joined end to end
// ----------------------------------------------------------------------------
//  channel | dir | word
//  --------+-----+---------------------------------------------------------
//  in_if   | in  | operation, record_length, record_handle, byte_position
//  out_if  | out | found, found_handle, found_length, offset_in_record
//
//  add: written to the store when taken, its all-zero result word is valid the next cycle
//  find: walks the ring from the oldest slot, one descriptor read per cycle
//    from the single read port of the store; the walk ends early when a
//    record matches
//  reset: pointers and per-slot valid bits clear at once, no clearing pass
//  a result word held by the sink keeps in_if.ready low
`timescale 1ns / 1ps
`default_nettype none

module record_ring_offset_lookup (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  rrol_in_if.sink      in_if,
  rrol_out_if.source   out_if
);
  import rrol_pkg::*;

  rrol_cmd_t cmd;
  rrol_sts_t sts;

  rrol_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_if.valid),
    .in_operation_i (in_if.operation),
    .in_ready_o     (in_if.ready),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  rrol_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .record_length_i    (in_if.record_length),
    .record_handle_i    (in_if.record_handle),
    .byte_position_i    (in_if.byte_position),
    .found_o            (out_if.found),
    .found_handle_o     (out_if.found_handle),
    .found_length_o     (out_if.found_length),
    .offset_in_record_o (out_if.offset_in_record)
  );

endmodule

`default_nettype wire

// ===== sv/rrol_checker.sv =====
// ----------------------------------------------------------------------------
// rrol_checker
// port-level checks of the record ring offset lookup, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "record_ring_offset_lookup_macros.svh"

module rrol_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_ready_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic                       found_i,
  input wire logic [rrol_pkg::HDL_W-1:0] found_handle_i,
  input wire logic [rrol_pkg::LEN_W-1:0] found_length_i,
  input wire logic [rrol_pkg::LEN_W-1:0] offset_in_record_i
);

  // stalled result word holds
  `RROL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({found_i, found_handle_i, found_length_i, offset_in_record_i}))

  // a miss or an add carries an all-zero word
  `RROL_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, out_valid_i && !found_i, (found_handle_i == '0) && (found_length_i == '0) && (offset_in_record_i == '0))

  // the offset lies inside the matched record
  `RROL_ASSERT_IMP(a_off_inside, clk_i, rst_ni, out_valid_i && found_i, offset_in_record_i < found_length_i)

  // no new word is taken while a result waits
  `RROL_ASSERT_IMP(a_no_take_stalled, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i)

endmodule

bind record_ring_offset_lookup rrol_checker u_rrol_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready_i         (in_if.ready),
  .out_valid_i        (out_if.valid),
  .out_ready_i        (out_if.ready),
  .found_i            (out_if.found),
  .found_handle_i     (out_if.found_handle),
  .found_length_i     (out_if.found_length),
  .offset_in_record_i (out_if.offset_in_record)
);

`default_nettype wire
